### rtl/gaussian_orbital_value_eval_assert.svh
// Assertion macros shared by the orbital evaluator RTL
`ifndef GAUSSIAN_ORBITAL_VALUE_EVAL_ASSERT_SVH
`define GAUSSIAN_ORBITAL_VALUE_EVAL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GOVE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GOVE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gove_pkg.sv
// Types, constants and arithmetic helpers for the orbital evaluator
`default_nettype none
package gove_pkg;

  localparam logic [1:0] CMD_LOAD_PRIM  = 2'd0;
  localparam logic [1:0] CMD_LOAD_XFORM = 2'd1;
  localparam logic [1:0] CMD_EVAL       = 2'd2;

  localparam logic [2:0] CFG_CENTER_X   = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z   = 3'd2;
  localparam logic [2:0] CFG_ANGULAR    = 3'd3;
  localparam logic [2:0] CFG_PURE       = 3'd4;
  localparam logic [2:0] CFG_PRIM_COUNT = 3'd5;

  localparam int         XFORM_DEPTH = 135;
  localparam logic [7:0] XFORM_COLS  = 8'd15;

  localparam logic [61:0]        MAG_CAP = 62'h2000000000000000;
  localparam logic signed [62:0] ONE_Q24 = 63'sh1000000;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  // factorial reciprocals in Q.30
  function automatic logic [30:0] inv_fact(input logic [3:0] n);
    logic [30:0] r;
    case (n)
      4'd0:    r = 31'd1073741824;
      4'd1:    r = 31'd1073741824;
      4'd2:    r = 31'd536870912;
      4'd3:    r = 31'd178956971;
      4'd4:    r = 31'd44739243;
      4'd5:    r = 31'd8947849;
      4'd6:    r = 31'd1491308;
      4'd7:    r = 31'd213044;
      4'd8:    r = 31'd26631;
      4'd9:    r = 31'd2959;
      4'd10:   r = 31'd296;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] cart_count(input logic [2:0] l);
    logic [3:0] r;
    case (l)
      3'd0:    r = 4'd1;
      3'd1:    r = 4'd3;
      3'd2:    r = 4'd6;
      3'd3:    r = 4'd10;
      default: r = 4'd15;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] abs33(input logic signed [32:0] x);
    logic [32:0] t;
    t = x[32] ? 33'(-x) : 33'(x);
    return t[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic [61:0] abs63(input logic signed [62:0] x);
    logic [62:0] t;
    t = x[62] ? 63'(-x) : 63'(x);
    return t[61:0];
  endfunction

  // (a*b)>>24 on magnitudes, capped at 2^61, sign applied
  function automatic logic signed [62:0] smul_val(input logic [127:0] prod, input logic neg);
    logic [61:0] mag;
    mag = (|prod[127:85]) ? MAG_CAP : {1'b0, prod[84:24]};
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [62:0] clamp_cap(input logic signed [63:0] x);
    logic signed [63:0] cap;
    cap = $signed({2'b00, MAG_CAP});
    if (x > cap) return 63'(cap);
    if (x < -cap) return 63'(-cap);
    return 63'(x);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [62:0] x);
    if (x > 63'sd2147483647) return 32'h7fffffff;
    if (x < -63'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

### rtl/gaussian_orbital_value_eval.sv
// Top level: Gaussian orbital value evaluator for one contracted shell
//
//  channel   direction  handshake             payload
//  in        into block in_valid / in_stall   cmd, table_index, prim_*, transform_coeff, point_*
//  out       from block out_valid / out_stall function_index, ao_value, last
//  cfg       into block cfg_we                cfg_index, cfg_data
//
// Loads (cmd 0 and 1) leave the engine idle. A point's work is a series of products, every
// one of them through the one shared multiplier: 3 for r2, up to 17 per primitive and
// 1+l per Cartesian function plus ncart per pure function; each primitive fetch, transform
// read and output also has a state of its own.
// Tables are held in RAMs with registered reads; reset clears control and configuration state only.
// A finished value waits in the output register; the engine stops on it only while stalled.
`default_nettype none
`include "gaussian_orbital_value_eval_assert.svh"
module gaussian_orbital_value_eval #(
  parameter int MAX_PRIMITIVES = 16,
  parameter int MAX_ANGULAR = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic [7:0]         table_index,
  input  wire logic [31:0]        prim_exponent,
  input  wire logic signed [31:0] prim_coefficient,
  input  wire logic signed [31:0] transform_coeff,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              function_index,
  output logic signed [31:0]      ao_value,
  output logic                    last,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int PW    = (MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1;
  localparam int LMAX  = (MAX_ANGULAR < 4) ? MAX_ANGULAR : 4;
  localparam int NCART = (LMAX + 1) * (LMAX + 2) / 2;
  localparam int CIW   = (NCART > 1) ? $clog2(NCART) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ    = 4'd1;
  localparam logic [3:0] ST_PRD   = 4'd2;
  localparam logic [3:0] ST_ALPHA = 4'd3;
  localparam logic [3:0] ST_HORN  = 4'd4;
  localparam logic [3:0] ST_SQR   = 4'd5;
  localparam logic [3:0] ST_COEF  = 4'd6;
  localparam logic [3:0] ST_MONO  = 4'd7;
  localparam logic [3:0] ST_TRD   = 4'd8;
  localparam logic [3:0] ST_TMUL  = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  logic [3:0] state, ret_state;
  logic       mwait;

  logic signed [31:0] center_x, center_y, center_z;
  logic [2:0]         angular_momentum;
  logic               pure_mode;
  logic [4:0]         primitive_count;

  logic signed [32:0] dx, dy, dz;
  logic [2:0]  l;
  logic [4:0]  np, k;
  logic        spherical;
  logic [3:0]  nout, ncart;
  logic [1:0]  j;
  logic [49:0] r2;
  logic [29:0] f;
  logic [30:0] p;
  logic [3:0]  h;
  logic [2:0]  sq;
  logic [24:0] e;
  logic signed [62:0] radial, v, acc, ev;
  logic [2:0]  lx, ly, rx, ry, rz;
  logic [3:0]  ci, m, i, oi;
  logic [7:0]  tbase;
  logic signed [62:0] cart [NCART];

  logic in_acc, mul_state, mneg;
  gove_pkg::mul_req_t mreq;
  gove_pkg::mul_rsp_t mrsp;
  logic signed [62:0] smul, acc_n;
  logic [63:0]  prim_rd;
  logic [31:0]  xform_rd;
  logic [29:0]  hprod;
  logic [30:0]  inv_h, p_horn, p_sq, e_sum;
  logic [60:0]  sq_sum;
  logic [2:0]   lx_n, ly_n, lz_n, l_in;
  logic         mono_end;
  logic [4:0]   np_in;
  logic signed [32:0] dsel;
  logic signed [62:0] cart_i;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  gove_ram #(.WIDTH(64), .DEPTH(MAX_PRIMITIVES), .AW(PW)) u_prim_ram (
    .clk   (clk),
    .we    (in_acc && cmd == gove_pkg::CMD_LOAD_PRIM &&
            {24'd0, table_index} < 32'(MAX_PRIMITIVES)),
    .waddr (table_index[PW-1:0]),
    .wdata ({prim_exponent, prim_coefficient}),
    .re    (state == ST_PRD && k != np),
    .raddr (PW'(k)),
    .rdata (prim_rd)
  );

  gove_ram #(.WIDTH(32), .DEPTH(gove_pkg::XFORM_DEPTH), .AW(8)) u_xform_ram (
    .clk   (clk),
    .we    (in_acc && cmd == gove_pkg::CMD_LOAD_XFORM &&
            table_index < 8'(gove_pkg::XFORM_DEPTH)),
    .waddr (table_index),
    .wdata (transform_coeff),
    .re    (state == ST_TRD),
    .raddr (tbase + {4'd0, i}),
    .rdata (xform_rd)
  );

  gove_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_comb begin
    l_in  = (angular_momentum > 3'(LMAX)) ? 3'(LMAX) : angular_momentum;
    np_in = ({27'd0, primitive_count} > MAX_PRIMITIVES) ? 5'(MAX_PRIMITIVES)
                                                          : primitive_count;
    case (j)
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
    cart_i = cart[i[CIW-1:0]];

    mul_state = (state == ST_SQ) || (state == ST_ALPHA) || (state == ST_HORN) ||
                (state == ST_SQR) || (state == ST_COEF) || (state == ST_MONO) ||
                (state == ST_TMUL);
    mreq.start = mul_state && !mwait;
    mreq.a = 64'd0;
    mreq.b = 64'd0;
    mneg   = 1'b0;
    case (state)
      ST_SQ: begin
        mreq.a = 64'(gove_pkg::abs33(dsel));
        mreq.b = 64'(gove_pkg::abs33(dsel));
      end
      ST_ALPHA: begin
        mreq.a = 64'(prim_rd[63:32]);
        mreq.b = 64'(r2);
      end
      ST_HORN: begin
        mreq.a = 64'(f);
        mreq.b = 64'(p);
      end
      ST_SQR: begin
        mreq.a = 64'(p);
        mreq.b = 64'(p);
      end
      ST_COEF: begin
        mreq.a = 64'(gove_pkg::abs32(prim_rd[31:0]));
        mreq.b = 64'(e);
        mneg   = prim_rd[31];
      end
      ST_MONO: begin
        mreq.a = 64'(gove_pkg::abs63(v));
        if (rx != 3'd0) begin
          mreq.b = 64'(gove_pkg::abs33(dx));
          mneg   = v[62] ^ dx[32];
        end else if (ry != 3'd0) begin
          mreq.b = 64'(gove_pkg::abs33(dy));
          mneg   = v[62] ^ dy[32];
        end else if (rz != 3'd0) begin
          mreq.b = 64'(gove_pkg::abs33(dz));
          mneg   = v[62] ^ dz[32];
        end else begin
          mreq.b = 64'(gove_pkg::abs63(radial));
          mneg   = v[62] ^ radial[62];
        end
      end
      ST_TMUL: begin
        mreq.a = 64'(gove_pkg::abs32(xform_rd));
        mreq.b = 64'(gove_pkg::abs63(cart_i));
        mneg   = xform_rd[31] ^ cart_i[62];
      end
      default: begin
        mneg = 1'b0;
      end
    endcase

    smul  = gove_pkg::smul_val(mrsp.prod, mneg);
    acc_n = gove_pkg::clamp_cap({acc[62], acc} + {smul[62], smul});

    // Horner step and squaring step of exp(-t/32)
    hprod  = mrsp.prod[59:30];
    inv_h  = gove_pkg::inv_fact(h);
    p_horn = ({1'b0, hprod} >= inv_h) ? 31'd0 : inv_h - {1'b0, hprod};
    sq_sum = mrsp.prod[60:0] + 61'h20000000;
    p_sq   = sq_sum[60:30];
    e_sum  = p_sq + 31'd32;

    // next monomial in standard order
    lx_n = lx;
    ly_n = ly;
    mono_end = 1'b0;
    if (ly != 3'd0) begin
      ly_n = ly - 3'd1;
    end else if (lx != 3'd0) begin
      lx_n = lx - 3'd1;
      ly_n = l - lx_n;
    end else begin
      mono_end = 1'b1;
    end
    lz_n = l - lx_n - ly_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      ret_state        <= ST_IDLE;
      mwait            <= 1'b0;
      out_valid        <= 1'b0;
      center_x         <= 32'sd0;
      center_y         <= 32'sd0;
      center_z         <= 32'sd0;
      angular_momentum <= 3'd0;
      pure_mode        <= 1'b0;
      primitive_count  <= 5'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gove_pkg::CFG_CENTER_X:   center_x <= cfg_data;
          gove_pkg::CFG_CENTER_Y:   center_y <= cfg_data;
          gove_pkg::CFG_CENTER_Z:   center_z <= cfg_data;
          gove_pkg::CFG_ANGULAR:    angular_momentum <= cfg_data[2:0];
          gove_pkg::CFG_PURE:       pure_mode <= cfg_data[0];
          gove_pkg::CFG_PRIM_COUNT: primitive_count <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (mrsp.done) begin
        mwait <= 1'b0;
      end else if (mreq.start) begin
        mwait <= 1'b1;
      end

      if (state == ST_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc && cmd == gove_pkg::CMD_EVAL) begin
            dx    <= {point_x[31], point_x} - {center_x[31], center_x};
            dy    <= {point_y[31], point_y} - {center_y[31], center_y};
            dz    <= {point_z[31], point_z} - {center_z[31], center_z};
            l     <= l_in;
            np    <= np_in;
            spherical <= pure_mode;
            ncart <= gove_pkg::cart_count(l_in);
            nout  <= pure_mode ? {l_in, 1'b1} : gove_pkg::cart_count(l_in);
            j     <= 2'd0;
            r2    <= 50'd0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (mrsp.done) begin
            r2 <= r2 + {2'd0, mrsp.prod[63:16]};
            if (j == 2'd2) begin
              k      <= 5'd0;
              radial <= 63'sd0;
              state  <= ST_PRD;
            end else begin
              j <= j + 2'd1;
            end
          end
        end
        ST_PRD: begin
          if (k == np) begin
            lx    <= l;
            ly    <= 3'd0;
            rx    <= l;
            ry    <= 3'd0;
            rz    <= 3'd0;
            v     <= gove_pkg::ONE_Q24;
            ci    <= 4'd0;
            state <= ST_MONO;
          end else begin
            state <= ST_ALPHA;
          end
        end
        ST_ALPHA: begin
          if (mrsp.done) begin
            // exponent argument of 32 or more underflows to zero
            if (|mrsp.prod[127:53]) begin
              e     <= 25'd0;
              state <= ST_COEF;
            end else begin
              f     <= {mrsp.prod[52:24], 1'b0};
              p     <= gove_pkg::inv_fact(4'd10);
              h     <= 4'd9;
              state <= ST_HORN;
            end
          end
        end
        ST_HORN: begin
          if (mrsp.done) begin
            p <= p_horn;
            if (h == 4'd0) begin
              sq    <= 3'd0;
              state <= ST_SQR;
            end else begin
              h <= h - 4'd1;
            end
          end
        end
        ST_SQR: begin
          if (mrsp.done) begin
            p <= p_sq;
            if (sq == 3'd4) begin
              e     <= e_sum[30:6];
              state <= ST_COEF;
            end else begin
              sq <= sq + 3'd1;
            end
          end
        end
        ST_COEF: begin
          if (mrsp.done) begin
            radial <= radial + smul;
            k      <= k + 5'd1;
            state  <= ST_PRD;
          end
        end
        ST_MONO: begin
          if (mrsp.done) begin
            if (rx != 3'd0) begin
              v  <= smul;
              rx <= rx - 3'd1;
            end else if (ry != 3'd0) begin
              v  <= smul;
              ry <= ry - 3'd1;
            end else if (rz != 3'd0) begin
              v  <= smul;
              rz <= rz - 3'd1;
            end else begin
              cart[ci[CIW-1:0]] <= smul;
              ci <= ci + 4'd1;
              lx <= lx_n;
              ly <= ly_n;
              rx <= lx_n;
              ry <= ly_n;
              rz <= lz_n;
              v  <= gove_pkg::ONE_Q24;
              if (mono_end) begin
                m     <= 4'd0;
                i     <= 4'd0;
                acc   <= 63'sd0;
                tbase <= 8'd0;
              end
              if (!spherical) begin
                ev        <= smul;
                oi        <= ci;
                ret_state <= mono_end ? ST_IDLE : ST_MONO;
                state     <= ST_EMIT;
              end else begin
                state <= mono_end ? ST_TRD : ST_MONO;
              end
            end
          end
        end
        ST_TRD: begin
          state <= ST_TMUL;
        end
        ST_TMUL: begin
          if (mrsp.done) begin
            if (i == ncart - 4'd1) begin
              ev    <= acc_n;
              oi    <= m;
              state <= ST_EMIT;
              if (m == nout - 4'd1) begin
                ret_state <= ST_IDLE;
              end else begin
                ret_state <= ST_TRD;
                m     <= m + 4'd1;
                tbase <= tbase + gove_pkg::XFORM_COLS;
                i     <= 4'd0;
                acc   <= 63'sd0;
              end
            end else begin
              acc   <= acc_n;
              i     <= i + 4'd1;
              state <= ST_TRD;
            end
          end
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            function_index <= oi;
            ao_value       <= gove_pkg::sat32(ev);
            last           <= (oi == nout - 4'd1);
            state          <= ret_state;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `GOVE_ASSERT_NEXT(a_eval_starts, clk, rst, in_acc && cmd == gove_pkg::CMD_EVAL, state == ST_SQ, "evaluate request did not start the r2 pass")
  `GOVE_ASSERT_NOW(a_done_expected, clk, rst, mrsp.done, mwait && mul_state, "multiplier result arrived with no product pending")
  `GOVE_ASSERT_NOW(a_emit_in_range, clk, rst, state == ST_EMIT, oi < nout, "function index beyond the shell size")
  `GOVE_ASSERT_NEXT(a_load_no_busy, clk, rst, in_acc && cmd != gove_pkg::CMD_EVAL, state == ST_IDLE, "table load left the engine busy")

endmodule
`default_nettype wire

### rtl/gove_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module gove_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/gove_mul.sv
// Shared 64x64 unsigned multiplier built from four 32x32 partial products
`default_nettype none
module gove_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gove_pkg::mul_req_t req,
  output gove_pkg::mul_rsp_t      rsp
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic [63:0]  a_r, b_r, pp, pp_next;
  logic [127:0] acc, pp_shifted;
  logic [2:0]   cnt;
  logic [1:0]   psh;
  logic         run, done;
  logic [31:0]  a_half, b_half;

  always_comb begin
    a_half  = cnt[1] ? a_r[63:32] : a_r[31:0];
    b_half  = cnt[0] ? b_r[63:32] : b_r[31:0];
    pp_next = 64'(a_half) * 64'(b_half);
    case (psh)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      2'd2:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = 128'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_r <= req.a;
        b_r <= req.b;
        acc <= 128'd0;
        cnt <= 3'd0;
        run <= 1'b1;
      end else if (run) begin
        if (cnt != LAST_STEP) begin
          pp  <= pp_next;
          psh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        // accumulate the partial product held in the pp register
        if (cnt != 3'd0) begin
          acc <= acc + pp_shifted;
        end
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule
`default_nettype wire

### tb/sv/tb_gaussian_orbital_value_eval.sv
// Testbench for the Gaussian orbital value evaluator: directed and random requests checked by a scoreboard
`timescale 1ns / 1ps
module tb_gaussian_orbital_value_eval;

  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    bit [3:0]  fn;
    bit [31:0] value;
    bit        last;
  } ao_result_t;

  class orbital_scoreboard;
    bit [31:0]   exponents[16];
    bit [31:0]   coeffs[16];
    bit [31:0]   xform[135];
    longint      cx, cy, cz;
    int unsigned lmom, spherical, nprim;
    ao_result_t  ao_queue[$];
    int          errors;
    bit [63:0]   inv_fact_q30[11];

    function new();
      cx = 0; cy = 0; cz = 0;
      lmom = 0; spherical = 0; nprim = 1;
      errors = 0;
      inv_fact_q30 = '{64'd1073741824, 64'd1073741824, 64'd536870912, 64'd178956971,
                       64'd44739243, 64'd8947849, 64'd1491308, 64'd213044, 64'd26631,
                       64'd2959, 64'd296};
    endfunction

    function longint sext(bit [31:0] v);
      return longint'(signed'(v));
    endfunction

    function bit [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // (a*b)>>24 on magnitudes with a cap at 2^61
    function longint qmul(longint a, longint b);
      bit [127:0] p;
      bit [63:0]  m;
      p = ({64'b0, mag(a)} * {64'b0, mag(b)}) >> 24;
      m = (p > 128'(64'h2000000000000000)) ? 64'h2000000000000000 : p[63:0];
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint cap_sum(longint v);
      if (v > 64'sh2000000000000000) return 64'sh2000000000000000;
      if (v < -64'sh2000000000000000) return -64'sh2000000000000000;
      return v;
    endfunction

    function bit [63:0] exp_neg(bit [63:0] t);
      bit [63:0] f, p, prod;
      if (t >= (64'd32 << 24)) return 0;
      f = t << 1;
      p = inv_fact_q30[10];
      for (int k = 9; k >= 0; k--) begin
        prod = (f * p) >> 30;
        p = (prod >= inv_fact_q30[k]) ? 64'd0 : inv_fact_q30[k] - prod;
      end
      for (int k = 0; k < 5; k++) p = (p * p + (64'd1 << 29)) >> 30;
      return (p + 32) >> 6;
    endfunction

    function bit [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function void set_register(bit [2:0] idx, bit [31:0] data);
      case (idx)
        gove_pkg::CFG_CENTER_X:   cx = sext(data);
        gove_pkg::CFG_CENTER_Y:   cy = sext(data);
        gove_pkg::CFG_CENTER_Z:   cz = sext(data);
        gove_pkg::CFG_ANGULAR:    lmom = data[2:0];
        gove_pkg::CFG_PURE:       spherical = data[0];
        gove_pkg::CFG_PRIM_COUNT: nprim = data[4:0];
        default: ;
      endcase
    endfunction

    function void note_request(bit [1:0] cmd, bit [7:0] idx, bit [31:0] alpha_in,
                               bit [31:0] coef_in, bit [31:0] xf_in,
                               bit [31:0] px, bit [31:0] py, bit [31:0] pz);
      longint     d[3], radial, v, acc;
      longint     cart[15], vals[15];
      bit [63:0]  r2, t, alpha, a;
      int         l, np, ncart, nout, lz;
      ao_result_t res;
      if (cmd == gove_pkg::CMD_LOAD_PRIM) begin
        if (idx < 16) begin
          exponents[idx] = alpha_in;
          coeffs[idx] = coef_in;
        end
        return;
      end
      if (cmd == gove_pkg::CMD_LOAD_XFORM) begin
        if (idx < gove_pkg::XFORM_DEPTH) xform[idx] = xf_in;
        return;
      end
      if (cmd != gove_pkg::CMD_EVAL) return;
      l = (lmom > 4) ? 4 : lmom;
      np = (nprim > 16) ? 16 : nprim;
      d[0] = sext(px) - cx;
      d[1] = sext(py) - cy;
      d[2] = sext(pz) - cz;
      r2 = 0;
      for (int i = 0; i < 3; i++) begin
        a = mag(d[i]);
        r2 += (a * a) >> 16;
      end
      radial = 0;
      for (int k = 0; k < np; k++) begin
        alpha = exponents[k];
        t = ((alpha * (r2 >> 32)) << 8) + ((alpha * (r2 & 64'hffffffff)) >> 24);
        radial += qmul(sext(coeffs[k]), longint'(exp_neg(t)));
      end
      ncart = 0;
      for (int lx = l; lx >= 0; lx--) begin
        for (int ly = l - lx; ly >= 0; ly--) begin
          lz = l - lx - ly;
          v = 64'sd1 << 24;
          for (int j = 0; j < lx; j++) v = qmul(v, d[0]);
          for (int j = 0; j < ly; j++) v = qmul(v, d[1]);
          for (int j = 0; j < lz; j++) v = qmul(v, d[2]);
          cart[ncart++] = qmul(v, radial);
        end
      end
      if (spherical) begin
        nout = 2 * l + 1;
        for (int m = 0; m < nout; m++) begin
          acc = 0;
          for (int i = 0; i < ncart; i++)
            if (m * 15 + i < gove_pkg::XFORM_DEPTH)
              acc = cap_sum(acc + qmul(sext(xform[m * 15 + i]), cart[i]));
          vals[m] = acc;
        end
      end else begin
        nout = ncart;
        for (int i = 0; i < ncart; i++) vals[i] = cart[i];
      end
      for (int i = 0; i < nout; i++) begin
        res.fn = 4'(i);
        res.value = sat(vals[i]);
        res.last = (i == nout - 1);
        ao_queue = {ao_queue, res};
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bit [3:0] fn, bit [31:0] value, bit lst);
      ao_result_t want;
      if (ao_queue.size() == 0) begin
        report($sformatf("unexpected result fn=%0d value=%h", fn, value));
        return;
      end
      want = ao_queue.pop_front();
      if (fn != want.fn) report($sformatf("function_index %0d, want %0d", fn, want.fn));
      if (value != want.value)
        report($sformatf("ao_value %h, want %h (fn %0d)", value, want.value, want.fn));
      if (lst != want.last) report($sformatf("last %0d, want %0d", lst, want.last));
    endtask
  endclass

  logic               clk, rst;
  logic               in_valid, in_stall;
  logic [1:0]         cmd;
  logic [7:0]         table_index;
  logic [31:0]        prim_exponent;
  logic signed [31:0] prim_coefficient, transform_coeff, point_x, point_y, point_z;
  logic               out_valid, out_stall;
  logic [3:0]         function_index;
  logic signed [31:0] ao_value;
  logic               last;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  orbital_scoreboard sb = new();
  int send_idle_pct, recv_stall_pct;

  gaussian_orbital_value_eval u_top (
    .clk, .rst, .in_valid, .in_stall, .cmd, .table_index, .prim_exponent,
    .prim_coefficient, .transform_coeff, .point_x, .point_y, .point_z,
    .out_valid, .out_stall, .function_index, .ao_value, .last,
    .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(function_index, ao_value, last);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task send_request(bit [1:0] c, bit [7:0] idx, bit [31:0] alpha, bit [31:0] coef,
                    bit [31:0] xf, bit [31:0] px, bit [31:0] py, bit [31:0] pz);
    in_valid <= 1'b1;
    cmd <= c;
    table_index <= idx;
    prim_exponent <= alpha;
    prim_coefficient <= coef;
    transform_coeff <= xf;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(c, idx, alpha, coef, xf, px, py, pz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task send_point(bit [31:0] px, bit [31:0] py, bit [31:0] pz);
    send_request(gove_pkg::CMD_EVAL, 8'($urandom), $urandom, $urandom, $urandom,
                 px, py, pz);
  endtask

  task load_primitive(bit [7:0] idx, bit [31:0] alpha, bit [31:0] coef);
    send_request(gove_pkg::CMD_LOAD_PRIM, idx, alpha, coef, $urandom, $urandom, $urandom,
                 $urandom);
  endtask

  task load_xform(bit [7:0] idx, bit [31:0] xf);
    send_request(gove_pkg::CMD_LOAD_XFORM, idx, $urandom, $urandom, xf, $urandom, $urandom,
                 $urandom);
  endtask

  // hold writes until the evaluator has drained
  task write_shell(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] l,
                   bit [31:0] sph, bit [31:0] np);
    bit [31:0] vals[6];
    in_valid <= 1'b0;
    while (sb.ao_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    vals = '{x, y, z, l, sph, np};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_register(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function bit [31:0] near(longint c);
    if ($urandom_range(99) < 80) return 32'(c + $urandom_range(0, 1 << 26) - (1 << 25));
    return $urandom;
  endfunction

  function bit [31:0] small_alpha();
    if ($urandom_range(99) < 85) return $urandom_range(0, 10 << 16);
    return $urandom;
  endfunction

  function bit [31:0] small_coef();
    if ($urandom_range(99) < 80) return 32'($urandom_range(0, 1 << 26) - (1 << 25));
    return $urandom;
  endfunction

  task random_items(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_point(near(sb.cx), near(sb.cy), near(sb.cz));
      else if (pick < 80)
        load_primitive(8'($urandom_range(0, 31)), small_alpha(), small_coef());
      else if (pick < 95)
        load_xform(8'($urandom_range(0, 255)), small_coef());
      else
        send_request(CMD_NONE, 8'($urandom), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
    end
  endtask

  int ang_list[10]   = '{0, 1, 2, 3, 4, 5, 7, 4, 2, 1};
  int prim_list[10]  = '{1, 16, 0, 3, 17, 31, 2, 1, 4, 2};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_NONE;
    table_index = 0;
    prim_exponent = 0;
    prim_coefficient = 0;
    transform_coeff = 0;
    point_x = 0;
    point_y = 0;
    point_z = 0;
    cfg_we = 1'b0;
    cfg_index = gove_pkg::CFG_CENTER_X;
    cfg_data = 0;
    send_idle_pct = 16;
    recv_stall_pct = 77;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every table entry that a point can read
    for (int i = 0; i < 16; i++) load_primitive(8'(i), small_alpha(), small_coef());
    for (int i = 0; i < gove_pkg::XFORM_DEPTH; i++) load_xform(8'(i), small_coef());

    // directed: ignored writes, unused command, extremes of the fields
    load_primitive(8'd16, 32'hffffffff, 32'h80000000);
    load_primitive(8'd255, 32'hffffffff, 32'h7fffffff);
    load_xform(8'd135, 32'h7fffffff);
    load_xform(8'd255, 32'h80000000);
    send_request(CMD_NONE, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_point(0, 0, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    load_primitive(0, 32'h0, 32'h7fffffff);
    send_point(32'h01000000, 32'hff000000, 0);
    load_primitive(0, 32'hffffffff, 32'h80000000);
    send_point(32'h00000001, 0, 0);
    send_point(0, 0, 0);
    load_primitive(0, 32'h0, 32'h80000000);
    write_shell(32'h80000000, 32'h7fffffff, 32'h80000000, 4, 0, 1);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
    write_shell(32'h80000000, 32'h7fffffff, 0, 4, 1, 1);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    load_primitive(0, 32'h00010000, 32'h01000000);
    write_shell(0, 0, 0, 2, 1, 0);
    send_point(32'h01000000, 32'h01000000, 32'h01000000);

    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        send_idle_pct = 77;
        recv_stall_pct = 16;
      end
      if (p == 7) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_shell(small_coef(), small_coef(), small_coef(), ang_list[p], p % 2, prim_list[p]);
      random_items(4);
    end

    in_valid <= 1'b0;
    while (sb.ao_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/gove_pkg.sv
rtl/gove_ram.sv
rtl/gove_mul.sv
rtl/gaussian_orbital_value_eval.sv
tb/sv/tb_gaussian_orbital_value_eval.sv
